FILE: src/mpar_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 2x2 max pool / argmax / ReLU block.
// No dependencies; imported by every module in src.
package mpar_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_PLANES   = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int PLANE_BITS   = $clog2(MAX_PLANES);
    localparam int WIDTH_BITS   = 9;
    localparam int PCOUNT_BITS  = 7;
    localparam int CFG_DATA_BITS = 9;
    localparam int CFG_ADDR_BITS = 2;
    localparam int POOLED_BITS  = 15;
    localparam int MASK_BITS    = 4;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(224);
    localparam logic [PCOUNT_BITS-1:0] PCOUNT_RESET = PCOUNT_BITS'(4);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_IMAGE_WIDTH = 2'd0,
        REG_PLANE_COUNT = 2'd1
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                shift;
        logic [COL_BITS-1:0] inject_idx;
    } line_ctrl_t;

    typedef struct packed {
        logic [POOLED_BITS-1:0] pooled;
        logic [MASK_BITS-1:0]   mask;
    } pool_res_t;

endpackage

FILE: src/mpar_cell.sv
`timescale 1ns / 1ps
// One cell of the top-row line store chain: loads the new sample or its
// left neighbor's value on each shift. Depends on mpar_pkg.
module mpar_cell
    import mpar_pkg::*;
(
    input  logic    aclk,
    input  logic    shift,
    input  logic    inject,
    input  sample_t sample,
    input  sample_t prev,
    output sample_t q
);

    sample_t q_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            q_reg <= inject ? sample : prev;
        end
    end

    assign q = q_reg;

endmodule

FILE: src/mpar_line.sv
`timescale 1ns / 1ps
// Top-row line store: a chain of mpar_cell with a movable entry point so the
// tail lags the input by exactly one row. Depends on mpar_pkg, mpar_cell.
module mpar_line
    import mpar_pkg::*;
(
    input  logic       aclk,
    input  line_ctrl_t ctrl,
    input  sample_t    sample,
    output sample_t    top_left,
    output sample_t    top_right
);

    sample_t chain [MAX_WIDTH];
    sample_t tl_reg;

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        localparam logic [COL_BITS-1:0] CELL_IDX = COL_BITS'(i);
        sample_t prev;
        if (i == 0) begin : g_head
            assign prev = sample;
        end else begin : g_body
            assign prev = chain[i-1];
        end
        mpar_cell u_cell (
            .aclk   (aclk),
            .shift  (ctrl.shift),
            .inject (ctrl.inject_idx == CELL_IDX),
            .sample (sample),
            .prev   (prev),
            .q      (chain[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            tl_reg <= chain[MAX_WIDTH-1];
        end
    end

    assign top_right = chain[MAX_WIDTH-1];
    assign top_left  = tl_reg;

endmodule

FILE: src/mpar_window.sv
`timescale 1ns / 1ps
// 2x2 window evaluation: maximum, ReLU clip and tie mask.
// Depends on mpar_pkg.
module mpar_window
    import mpar_pkg::*;
(
    input  sample_t   tl,
    input  sample_t   tr,
    input  sample_t   bl,
    input  sample_t   br,
    output pool_res_t res
);

    sample_t max_top;
    sample_t max_bot;
    sample_t max_all;

    always_comb begin
        max_top = (tl > tr) ? tl : tr;
        max_bot = (bl > br) ? bl : br;
        max_all = (max_top > max_bot) ? max_top : max_bot;
        res.mask = {br == max_all, bl == max_all, tr == max_all, tl == max_all};
        if (max_all <= sample_t'(0)) begin
            res.pooled = '0;
        end else begin
            res.pooled = max_all[POOLED_BITS-1:0];
        end
    end

endmodule

FILE: src/max_pool_argmax_relu.sv
`timescale 1ns / 1ps
// 2x2 max pool with argmax mask and ReLU. Depends on mpar_pkg, mpar_line,
// mpar_window. The result and its valid are registered when the window's last pixel is accepted.
// Throughput: 1 sample per cycle unless m_ready stalls the output; the line store chain shifts once per sample.
// Sync active-low reset clears counters, left sample, config and output valid;
// line store cells are not cleared and need no clearing pass.
module max_pool_argmax_relu
    import mpar_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wen,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [POOLED_BITS-1:0]   m_pooled,
    output logic [MASK_BITS-1:0]     m_winner_mask,
    output logic [PLANE_BITS-1:0]    m_plane_index,
    output logic                     m_frame_last
);

    logic [WIDTH_BITS-1:0]  width_reg, width_next;
    logic [PCOUNT_BITS-1:0] pcount_reg, pcount_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [COL_BITS-1:0]    row_reg, row_next;
    logic [PLANE_BITS-1:0]  plane_reg, plane_next;
    sample_t                left_reg, left_next;
    logic                   out_valid_reg, out_valid_next;
    pool_res_t              out_res_reg, out_res_next;
    logic [PLANE_BITS-1:0]  out_plane_reg, out_plane_next;
    logic                   out_last_reg, out_last_next;

    logic [WIDTH_BITS-1:0]  eff_width;
    logic [WIDTH_BITS-1:0]  inject_wide;
    logic [COL_BITS-1:0]    width_m1;
    logic [PLANE_BITS-1:0]  planes_m1;
    logic                   s_acc;
    logic                   produce;
    logic                   restart;
    line_ctrl_t             line_ctrl;
    sample_t                top_left, top_right;
    pool_res_t              win_res;

    always_comb begin
        eff_width = {width_reg[WIDTH_BITS-1:1], 1'b0};
        if (eff_width < WIDTH_BITS'(2)) begin
            eff_width = WIDTH_BITS'(2);
        end else if (eff_width > WIDTH_BITS'(MAX_WIDTH)) begin
            eff_width = WIDTH_BITS'(MAX_WIDTH);
        end
        width_m1    = COL_BITS'(eff_width - WIDTH_BITS'(1));
        inject_wide = WIDTH_BITS'(MAX_WIDTH) - eff_width;
        if (pcount_reg == '0) begin
            planes_m1 = '0;
        end else if (pcount_reg > PCOUNT_BITS'(MAX_PLANES)) begin
            planes_m1 = PLANE_BITS'(MAX_PLANES - 1);
        end else begin
            planes_m1 = PLANE_BITS'(pcount_reg - PCOUNT_BITS'(1));
        end
    end

    assign s_ready = !out_valid_reg || m_ready;
    assign s_acc   = s_valid && s_ready;
    assign produce = row_reg[0] && col_reg[0];
    assign restart = cfg_wen &&
                     (cfg_addr == REG_IMAGE_WIDTH || cfg_addr == REG_PLANE_COUNT);

    assign line_ctrl.shift      = s_acc;
    assign line_ctrl.inject_idx = inject_wide[COL_BITS-1:0];

    mpar_line u_line (
        .aclk      (aclk),
        .ctrl      (line_ctrl),
        .sample    (s_sample),
        .top_left  (top_left),
        .top_right (top_right)
    );

    mpar_window u_window (
        .tl  (top_left),
        .tr  (top_right),
        .bl  (left_reg),
        .br  (s_sample),
        .res (win_res)
    );

    always_comb begin
        width_next     = width_reg;
        pcount_next    = pcount_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        plane_next     = plane_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_plane_next = out_plane_reg;
        out_last_next  = out_last_reg;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (restart) begin
            if (cfg_addr == REG_IMAGE_WIDTH) begin
                width_next = cfg_wdata[WIDTH_BITS-1:0];
            end else begin
                pcount_next = cfg_wdata[PCOUNT_BITS-1:0];
            end
            col_next   = '0;
            row_next   = '0;
            plane_next = '0;
            left_next  = '0;
        end else if (s_acc) begin
            if (row_reg[0] && !col_reg[0]) begin
                left_next = s_sample;
            end
            if (produce) begin
                out_valid_next = 1'b1;
                out_res_next   = win_res;
                out_plane_next = plane_reg;
                out_last_next  = (plane_reg == planes_m1) && (row_reg == width_m1) &&
                                 (col_reg == width_m1);
            end
            if (col_reg == width_m1) begin
                col_next = '0;
                if (row_reg == width_m1) begin
                    row_next   = '0;
                    plane_next = (plane_reg == planes_m1) ? '0 : plane_reg + 1'b1;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_RESET;
            pcount_reg    <= PCOUNT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            plane_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            width_reg     <= width_next;
            pcount_reg    <= pcount_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            plane_reg     <= plane_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg   <= out_res_next;
        out_plane_reg <= out_plane_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_pooled      = out_res_reg.pooled;
    assign m_winner_mask = out_res_reg.mask;
    assign m_plane_index = out_plane_reg;
    assign m_frame_last  = out_last_reg;

    a_rose_from_window: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && row_reg[0] && col_reg[0]))
        else $error("result request without a closing window pixel");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= width_m1) && (row_reg <= width_m1) && (plane_reg <= planes_m1))
        else $error("position counters beyond plane size");

    a_mask_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_winner_mask != '0))
        else $error("window result with empty winner mask");

    a_last_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_last) |-> (m_plane_index == planes_m1))
        else $error("frame end marked outside the last plane");

endmodule

FILE: verif/mpar_pool_checker.sv
`timescale 1ns / 1ps
// Checker for max_pool_argmax_relu: follows config writes and accepted samples,
// predicts each pooled window and compares the result channel. Uses mpar_pkg.
module mpar_pool_checker
    import mpar_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [CFG_ADDR_BITS-1:0]      cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [POOLED_BITS-1:0]        m_pooled,
    input  logic [MASK_BITS-1:0]          m_winner_mask,
    input  logic [PLANE_BITS-1:0]         m_plane_index,
    input  logic                          m_frame_last,
    output int                            fail_count = 0,
    output int                            windows_pending = 0,
    output int                            windows_checked = 0
);

    typedef struct packed {
        logic [POOLED_BITS-1:0] pooled;
        logic [MASK_BITS-1:0]   mask;
        logic [PLANE_BITS-1:0]  plane;
        logic                   last;
    } window_t;

    window_t                pending_windows [$];
    sample_t                top_row [MAX_WIDTH];
    sample_t                left_px;
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [PCOUNT_BITS-1:0] planes_reg;
    int                     col_idx;
    int                     row_idx;
    int                     plane_idx;

    function automatic int side_len();
        int w;
        w = int'({width_reg[WIDTH_BITS-1:1], 1'b0});
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int frame_planes();
        int p;
        p = int'(planes_reg);
        if (p < 1) p = 1;
        if (p > MAX_PLANES) p = MAX_PLANES;
        return p;
    endfunction

    function automatic void restart_frame();
        left_px   = '0;
        col_idx   = 0;
        row_idx   = 0;
        plane_idx = 0;
    endfunction

    function automatic void pool_sample(sample_t px);
        int      w;
        int      p;
        sample_t tl;
        sample_t tr;
        sample_t peak;
        window_t win;
        w = side_len();
        p = frame_planes();
        if (row_idx[0] == 1'b0) begin
            top_row[col_idx] = px;
        end else if (col_idx[0] == 1'b0) begin
            left_px = px;
        end else begin
            tl   = top_row[col_idx - 1];
            tr   = top_row[col_idx];
            peak = tl;
            if (tr > peak) peak = tr;
            if (left_px > peak) peak = left_px;
            if (px > peak) peak = px;
            win.pooled = (peak > 0) ? peak[POOLED_BITS-1:0] : '0;
            win.mask   = {px == peak, left_px == peak, tr == peak, tl == peak};
            win.plane  = plane_idx[PLANE_BITS-1:0];
            win.last   = (plane_idx == p - 1) && (row_idx == w - 1) && (col_idx == w - 1);
            pending_windows.push_back(win);
        end
        col_idx++;
        if (col_idx >= w) begin
            col_idx = 0;
            row_idx++;
            if (row_idx >= w) begin
                row_idx = 0;
                plane_idx++;
                if (plane_idx >= p) plane_idx = 0;
            end
        end
    endfunction

    always @(posedge aclk) begin
        window_t want;
        if (!aresetn) begin
            pending_windows.delete();
            width_reg  = WIDTH_RESET;
            planes_reg = PCOUNT_RESET;
            restart_frame();
        end else begin
            if (cfg_wen) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH: begin
                        width_reg = cfg_wdata[WIDTH_BITS-1:0];
                        restart_frame();
                    end
                    REG_PLANE_COUNT: begin
                        planes_reg = cfg_wdata[PCOUNT_BITS-1:0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_windows.size() == 0) begin
                    $error("unexpected window: pooled %0d mask %h plane %0d last %0d",
                           m_pooled, m_winner_mask, m_plane_index, m_frame_last);
                    fail_count++;
                end else begin
                    want = pending_windows.pop_front();
                    windows_checked++;
                    if (m_pooled !== want.pooled) begin
                        $error("pooled: expected %0d, got %0d", want.pooled, m_pooled);
                        fail_count++;
                    end
                    if (m_winner_mask !== want.mask) begin
                        $error("winner_mask: expected %h, got %h", want.mask, m_winner_mask);
                        fail_count++;
                    end
                    if (m_plane_index !== want.plane) begin
                        $error("plane_index: expected %0d, got %0d", want.plane, m_plane_index);
                        fail_count++;
                    end
                    if (m_frame_last !== want.last) begin
                        $error("frame_last: expected %0d, got %0d", want.last, m_frame_last);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) pool_sample(s_sample);
        end
        windows_pending = pending_windows.size();
    end

endmodule

FILE: verif/tb_max_pool_argmax_relu.sv
`timescale 1ns / 1ps
// Top of the max_pool_argmax_relu testbench: clock, reset, config writes and
// sample requests; checking is done by mpar_pool_checker. Uses mpar_pkg.
module tb_max_pool_argmax_relu;
    import mpar_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_HI = 2'd3;
    localparam int PHASES       = 8;
    localparam int CORNER_PX    = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wen   = 1'b0;
    logic [CFG_ADDR_BITS-1:0]      cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample  = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [POOLED_BITS-1:0]        m_pooled;
    logic [MASK_BITS-1:0]          m_winner_mask;
    logic [PLANE_BITS-1:0]         m_plane_index;
    logic                          m_frame_last;

    int fail_count;
    int windows_pending;
    int windows_checked;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int samples_sent = 0;
    int cycle_cnt    = 0;

    int phase_width  [PHASES] = '{4, 256, 3, 1, 510, 6, 8, 0};
    int phase_planes [PHASES] = '{3, 64, 'h17F, 0, 'h1C0, 5, 1, 64};
    int phase_items  [PHASES] = '{120, 512, 280, 80, 280, 150, 150, 120};
    sample_t corner_px [CORNER_PX];

    max_pool_argmax_relu uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pooled      (m_pooled),
        .m_winner_mask (m_winner_mask),
        .m_plane_index (m_plane_index),
        .m_frame_last  (m_frame_last)
    );

    mpar_pool_checker pool_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pooled        (m_pooled),
        .m_winner_mask   (m_winner_mask),
        .m_plane_index   (m_plane_index),
        .m_frame_last    (m_frame_last),
        .fail_count      (fail_count),
        .windows_pending (windows_pending),
        .windows_checked (windows_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d windows outstanding", cycle_cnt, windows_pending);
        $display("TB_ERROR");
        $finish;
    end

    // entered and left at a falling edge; valid stays up for a back-to-back request
    task automatic push_sample(input sample_t px);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= px;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_windows();
        s_valid <= 1'b0;
        while (windows_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr, input int value);
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[CFG_DATA_BITS-1:0];
        @(negedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    // biased toward extremes and tiny values so windows tie often
    function automatic sample_t random_sample();
        case ($urandom_range(9))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2, 3, 4: return sample_t'(int'($urandom_range(6)) - 3);
            5: return sample_t'($urandom_range(3));
            default: return sample_t'($urandom());
        endcase
    endfunction

    task automatic run_phase(input int n_items, input idle_mode_t mode);
        int hold_at;
        hold_at   = $urandom_range(n_items - 1);
        gap_pct   = (mode == IDLE_SENDER) ? 84 : (mode == IDLE_BOTH) ? 20 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 20 : 0;
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at) drain_windows();
            push_sample(random_sample());
        end
        drain_windows();
    endtask

    initial begin
        corner_px = '{32767, -32768, -32768, 0,
                      -1, -1, -1, -1,
                      -32768, -32768, -32768, -32768,
                      0, 5, 5, -7,
                      100, 32767, 32767, 32767,
                      -5, -3, -4, -3};
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 2x2 planes, two per frame; writes to unused indexes must not restart
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_PLANE_COUNT, 2);
        for (int i = 0; i < CORNER_PX; i++) begin
            if (i == 4) begin
                drain_windows();
                write_reg(REG_SPARE_LO, 0);
                write_reg(REG_SPARE_HI, 'h1FF);
            end
            push_sample(corner_px[i]);
        end
        drain_windows();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_IMAGE_WIDTH, phase_width[ph]);
            write_reg(REG_PLANE_COUNT, phase_planes[ph]);
            run_phase(phase_items[ph], idle_mode_t'(ph % 4));
        end

        $display("Checked %0d pooled windows from %0d samples: corner windows and %0d settings,",
                 windows_checked, samples_sent, PHASES + 1);
        $display("widths 2 to 256 incl. clipped/odd values, 1 to 64 planes, idle and stall mixes.");
        if (fail_count == 0 && windows_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: max_pool_argmax_relu.f
src/mpar_pkg.sv
src/mpar_cell.sv
src/mpar_line.sv
src/mpar_window.sv
src/max_pool_argmax_relu.sv
verif/mpar_pool_checker.sv
verif/tb_max_pool_argmax_relu.sv
